// File: rtl/cell_grid_dirty_rect_tracker_defines.svh
// Assertion macros shared by the RTL. Each takes a label, an antecedent and a consequent.
`ifndef CELL_GRID_DIRTY_RECT_TRACKER_DEFINES_SVH
`define CELL_GRID_DIRTY_RECT_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define CGDR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgdr assertion failed");
`define CGDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgdr assertion failed");
`else
`define CGDR_ASSERT_IMPL(label, ante, cons)
`define CGDR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/cgdr_pkg.sv
package cgdr_pkg;

	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;
	localparam int TYPE_BITS_DEF   = 4;

	localparam int IDX_W   = 12;
	localparam int NTYPE_W = 4;
	localparam int COL_W   = 32;
	localparam int CNT_W   = 13;
	localparam int COORD_W = 7;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_WAKE  = 2'd2,
		OP_FRAME = 2'd3
	} op_t;

endpackage

// File: rtl/cgdr_in_if.sv
interface cgdr_in_if;
	logic                          valid;
	logic                          ready;
	cgdr_pkg::op_t                 op;
	logic [cgdr_pkg::IDX_W-1:0]    cell_index;
	logic [cgdr_pkg::NTYPE_W-1:0]  new_type;
	logic [cgdr_pkg::COL_W-1:0]    new_colour;

	modport source (output valid, op, cell_index, new_type, new_colour, input ready);
	modport sink (input valid, op, cell_index, new_type, new_colour, output ready);
endinterface

// File: rtl/cgdr_out_if.sv
interface cgdr_out_if;
	logic                                valid;
	logic                                ready;
	logic [cgdr_pkg::NTYPE_W-1:0]        cell_type;
	logic [cgdr_pkg::COL_W-1:0]          cell_color;
	logic [cgdr_pkg::CNT_W-1:0]          filled_count;
	logic                                chunk_empty;
	logic [cgdr_pkg::COORD_W-1:0]        dirty_min_x;
	logic [cgdr_pkg::COORD_W-1:0]        dirty_min_y;
	logic signed [cgdr_pkg::COORD_W-1:0] dirty_max_x;
	logic signed [cgdr_pkg::COORD_W-1:0] dirty_max_y;

	modport source (output valid, cell_type, cell_color, filled_count, chunk_empty,
		dirty_min_x, dirty_min_y, dirty_max_x, dirty_max_y, input ready);
	modport sink (input valid, cell_type, cell_color, filled_count, chunk_empty,
		dirty_min_x, dirty_min_y, dirty_max_x, dirty_max_y, output ready);
endinterface

// File: rtl/cell_grid_dirty_rect_tracker.sv
// Latency: an input transfer passes through stage 1, stage 2 and the output register before its result is valid.
// Throughput: one item per cycle, set by one read and one write of the cell memory per cycle
// with write-to-read forwarding; the whole pipeline and the input stall while a result waits.
// Reset clears counters and rectangles at once, then a clearing pass writes each of the
// min(GRID_WIDTH*GRID_HEIGHT, 4096) memory cells (4096 at the defaults) to empty, one per cycle,
// during which no item is taken.
`include "cell_grid_dirty_rect_tracker_defines.svh"

module cell_grid_dirty_rect_tracker #(
	parameter int GRID_WIDTH  = cgdr_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = cgdr_pkg::GRID_HEIGHT_DEF,
	parameter int TYPE_BITS   = cgdr_pkg::TYPE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	cgdr_in_if.sink           cmd,
	cgdr_out_if.source        rsp
);
	import cgdr_pkg::*;

	localparam int NCELLS    = GRID_WIDTH * GRID_HEIGHT;
	localparam int MEM_DEPTH = (NCELLS < (1 << IDX_W)) ? NCELLS : (1 << IDX_W);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int MW        = TYPE_BITS + COL_W;
	localparam int CW_CNT    = $clog2(MEM_DEPTH + 1);
	localparam int DIM_MAX   = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
	localparam int CW        = $clog2(DIM_MAX + 3) + 1;
	localparam int XB        = $clog2(GRID_WIDTH);
	localparam int RK        = 24;
	localparam int PW        = RK + IDX_W;
	localparam logic [RK-1:0] RECIP = RK'((1 << RK) / GRID_WIDTH + 1);
	localparam logic [31:0] NCELLS_C = 32'(NCELLS);
	localparam logic [IDX_W-1:0] WIDTH_I = IDX_W'(GRID_WIDTH);
	localparam logic signed [CW-1:0] W_C    = CW'(GRID_WIDTH);
	localparam logic signed [CW-1:0] H_C    = CW'(GRID_HEIGHT);
	localparam logic signed [CW-1:0] MARGIN = CW'(2);
	localparam logic signed [CW-1:0] NEG1   = '1;
	localparam logic signed [CW-1:0] ZERO_C = '0;

	logic [MW-1:0] mem [MEM_DEPTH];

	logic                 clr_busy_q;
	logic [AW-1:0]        clr_addr_q;
	logic [CW_CNT-1:0]    filled_q;
	logic signed [CW-1:0] pmin_x_q, pmin_y_q, pmax_x_q, pmax_y_q;
	logic signed [CW-1:0] qmin_x_q, qmin_y_q, qmax_x_q, qmax_y_q;

	logic                 v_s1, valid_s1, fwd_s1;
	op_t                  op_s1;
	logic [IDX_W-1:0]     idx_s1, y_s1;
	logic [TYPE_BITS-1:0] ntype_s1;
	logic [COL_W-1:0]     ncol_s1;
	logic [MW-1:0]        rd_s1, fwd_data_s1;

	logic                 v_s2, valid_s2;
	op_t                  op_s2;
	logic signed [CW-1:0] lx_s2, ly_s2, hx_s2, hy_s2;
	logic [TYPE_BITS-1:0] otype_s2;
	logic [COL_W-1:0]     ocol_s2;
	logic [CW_CNT-1:0]    cnt_s2;

	logic                      out_v_q;
	logic [NTYPE_W-1:0]        out_type_q;
	logic [COL_W-1:0]          out_col_q;
	logic [CNT_W-1:0]          out_cnt_q;
	logic                      out_empty_q;
	logic [COORD_W-1:0]        out_min_x_q, out_min_y_q;
	logic signed [COORD_W-1:0] out_max_x_q, out_max_y_q;

	logic                 adv, acc, s1_wr, in_valid, mem_we;
	logic [AW-1:0]        mem_wa;
	logic [MW-1:0]        mem_wd, old_cell;
	logic [TYPE_BITS-1:0] otype;
	logic [COL_W-1:0]     ocol;
	logic [CW_CNT-1:0]    cnt_next;
	logic [PW-1:0]        prod;
	logic [IDX_W-1:0]     yw;
	logic [XB-1:0]        x_u;
	logic signed [CW-1:0] xs, ys, lx, ly, hx, hy;
	logic signed [CW-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
	logic signed [CW-1:0] bmin_x, bmin_y, bmax_x, bmax_y;

	assign adv       = !out_v_q || rsp.ready;
	assign cmd.ready = adv && !clr_busy_q;
	assign acc       = cmd.valid && cmd.ready;
	assign in_valid  = {{(32 - IDX_W){1'b0}}, cmd.cell_index} < NCELLS_C;
	assign s1_wr     = v_s1 && valid_s1 && (op_s1 == OP_WRITE);
	assign prod      = PW'(cmd.cell_index) * PW'(RECIP);

	assign mem_we = clr_busy_q || (adv && s1_wr);
	assign mem_wa = clr_busy_q ? clr_addr_q : idx_s1[AW-1:0];
	assign mem_wd = clr_busy_q ? '0 : {ntype_s1, ncol_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (adv) begin
			rd_s1 <= mem[cmd.cell_index[AW-1:0]];
		end
	end

	always_comb begin
		old_cell = fwd_s1 ? fwd_data_s1 : rd_s1;
		otype    = valid_s1 ? old_cell[MW-1:COL_W] : '0;
		ocol     = valid_s1 ? old_cell[COL_W-1:0] : '0;
		cnt_next = filled_q;
		if (s1_wr) begin
			if (otype == '0 && ntype_s1 != '0) begin
				cnt_next = filled_q + 1'b1;
			end else if (otype != '0 && ntype_s1 == '0 && filled_q != '0) begin
				cnt_next = filled_q - 1'b1;
			end
		end
		yw  = IDX_W'(y_s1 * WIDTH_I);
		x_u = XB'(idx_s1 - yw);
		xs  = $signed(CW'(x_u));
		ys  = $signed(CW'(y_s1));
		lx  = (xs < MARGIN) ? ZERO_C : xs - MARGIN;
		ly  = (ys < MARGIN) ? ZERO_C : ys - MARGIN;
		hx  = (xs + MARGIN > W_C + NEG1) ? W_C + NEG1 : xs + MARGIN;
		hy  = (ys + MARGIN > H_C + NEG1) ? H_C + NEG1 : ys + MARGIN;
	end

	always_comb begin
		nmin_x = pmin_x_q;
		nmin_y = pmin_y_q;
		nmax_x = pmax_x_q;
		nmax_y = pmax_y_q;
		bmin_x = qmin_x_q;
		bmin_y = qmin_y_q;
		bmax_x = qmax_x_q;
		bmax_y = qmax_y_q;
		if (op_s2 == OP_FRAME) begin
			bmin_x = pmin_x_q;
			bmin_y = pmin_y_q;
			bmax_x = pmax_x_q;
			bmax_y = pmax_y_q;
			nmin_x = W_C;
			nmin_y = H_C;
			nmax_x = NEG1;
			nmax_y = NEG1;
		end else if (valid_s2 && (op_s2 == OP_WRITE || op_s2 == OP_WAKE)) begin
			if (lx_s2 < pmin_x_q) nmin_x = lx_s2;
			if (ly_s2 < pmin_y_q) nmin_y = ly_s2;
			if (hx_s2 > pmax_x_q) nmax_x = hx_s2;
			if (hy_s2 > pmax_y_q) nmax_y = hy_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			filled_q   <= '0;
			pmin_x_q   <= W_C;
			pmin_y_q   <= H_C;
			pmax_x_q   <= NEG1;
			pmax_y_q   <= NEG1;
			qmin_x_q   <= W_C;
			qmin_y_q   <= H_C;
			qmax_x_q   <= NEG1;
			qmax_y_q   <= NEG1;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			fwd_s1     <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1    <= acc;
				v_s2    <= v_s1;
				out_v_q <= v_s2;
				fwd_s1  <= acc && s1_wr && in_valid &&
					(cmd.cell_index[AW-1:0] == idx_s1[AW-1:0]);
				if (v_s1) begin
					filled_q <= cnt_next;
				end
				if (v_s2) begin
					pmin_x_q <= nmin_x;
					pmin_y_q <= nmin_y;
					pmax_x_q <= nmax_x;
					pmax_y_q <= nmax_y;
					qmin_x_q <= bmin_x;
					qmin_y_q <= bmin_y;
					qmax_x_q <= bmax_x;
					qmax_y_q <= bmax_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1       <= cmd.op;
			idx_s1      <= cmd.cell_index;
			valid_s1    <= in_valid;
			ntype_s1    <= TYPE_BITS'(cmd.new_type);
			ncol_s1     <= cmd.new_colour;
			y_s1        <= prod[PW-1:RK];
			fwd_data_s1 <= {ntype_s1, ncol_s1};

			op_s2       <= op_s1;
			valid_s2    <= valid_s1;
			lx_s2       <= lx;
			ly_s2       <= ly;
			hx_s2       <= hx;
			hy_s2       <= hy;
			otype_s2    <= otype;
			ocol_s2     <= ocol;
			cnt_s2      <= cnt_next;

			out_type_q  <= NTYPE_W'(otype_s2);
			out_col_q   <= ocol_s2;
			out_cnt_q   <= CNT_W'(cnt_s2);
			out_empty_q <= (cnt_s2 == '0);
			out_min_x_q <= COORD_W'(bmin_x);
			out_min_y_q <= COORD_W'(bmin_y);
			out_max_x_q <= COORD_W'(bmax_x);
			out_max_y_q <= COORD_W'(bmax_y);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.cell_type    = out_type_q;
	assign rsp.cell_color   = out_col_q;
	assign rsp.filled_count = out_cnt_q;
	assign rsp.chunk_empty  = out_empty_q;
	assign rsp.dirty_min_x  = out_min_x_q;
	assign rsp.dirty_min_y  = out_min_y_q;
	assign rsp.dirty_max_x  = out_max_x_q;
	assign rsp.dirty_max_y  = out_max_y_q;

	`CGDR_ASSERT_IMPL(a_no_accept_in_clear, clr_busy_q, !acc)
	`CGDR_ASSERT_NEXT(a_fwd_on_same_cell, acc && s1_wr && in_valid && (cmd.cell_index[AW-1:0] == idx_s1[AW-1:0]), fwd_s1)
	`CGDR_ASSERT_NEXT(a_frame_clears_pending, adv && v_s2 && op_s2 == OP_FRAME, pmin_x_q == W_C && pmin_y_q == H_C && pmax_x_q == NEG1 && pmax_y_q == NEG1)
	`CGDR_ASSERT_NEXT(a_count_step, 1'b1, (filled_q == $past(filled_q)) || (filled_q == $past(filled_q) + 1'b1) || (filled_q == $past(filled_q) - 1'b1))

endmodule

// File: tb/cgdr_checker.sv
`timescale 1ns / 1ps

module cgdr_checker (
	input  logic clk,
	input  logic arst_n,
	cgdr_in_if   cmd,
	cgdr_out_if  rsp,
	output int   fail_count,
	output int   pending
);
	import cgdr_pkg::*;

	localparam int GW     = GRID_WIDTH_DEF;
	localparam int GH     = GRID_HEIGHT_DEF;
	localparam int CELLS  = GW * GH;
	localparam int MARGIN = 2;

	typedef struct {
		logic [NTYPE_W-1:0] cell_type;
		logic [COL_W-1:0]   cell_color;
		logic [CNT_W-1:0]   filled_count;
		logic               chunk_empty;
		logic [COORD_W-1:0] min_x;
		logic [COORD_W-1:0] min_y;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] max_y;
	} cell_result_t;

	cell_result_t expected_results[$];

	logic [NTYPE_W-1:0] type_mem [CELLS];
	logic [COL_W-1:0]   colour_mem [CELLS];
	int filled;
	int pend_min_x, pend_min_y, pend_max_x, pend_max_y;
	int pub_min_x, pub_min_y, pub_max_x, pub_max_y;

	task automatic report_failure(string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void grow_pending(int idx);
		int x;
		int y;
		x = idx % GW;
		y = idx / GW;
		pend_min_x = (x - MARGIN < 0) ? 0 : ((x - MARGIN < pend_min_x) ? x - MARGIN : pend_min_x);
		pend_min_y = (y - MARGIN < 0) ? 0 : ((y - MARGIN < pend_min_y) ? y - MARGIN : pend_min_y);
		x = (x + MARGIN > GW - 1) ? GW - 1 : x + MARGIN;
		y = (y + MARGIN > GH - 1) ? GH - 1 : y + MARGIN;
		if (x > pend_max_x) pend_max_x = x;
		if (y > pend_max_y) pend_max_y = y;
	endfunction

	function automatic cell_result_t apply_cell_op(op_t op, logic [IDX_W-1:0] idx,
			logic [NTYPE_W-1:0] ntype, logic [COL_W-1:0] ncol);
		cell_result_t r;
		bit in_grid;
		logic [NTYPE_W-1:0] t;
		in_grid = int'(idx) < CELLS;
		t = ntype & NTYPE_W'((1 << TYPE_BITS_DEF) - 1);
		r.cell_type = in_grid ? type_mem[idx] : '0;
		r.cell_color = in_grid ? colour_mem[idx] : '0;
		case (op)
			OP_WRITE: begin
				if (in_grid) begin
					if (type_mem[idx] == 0 && t != 0)
						filled++;
					else if (type_mem[idx] != 0 && t == 0 && filled > 0)
						filled--;
					type_mem[idx] = t;
					colour_mem[idx] = ncol;
					grow_pending(int'(idx));
				end
			end
			OP_WAKE: begin
				if (in_grid)
					grow_pending(int'(idx));
			end
			OP_FRAME: begin
				pub_min_x = pend_min_x;
				pub_min_y = pend_min_y;
				pub_max_x = pend_max_x;
				pub_max_y = pend_max_y;
				pend_min_x = GW;
				pend_min_y = GH;
				pend_max_x = -1;
				pend_max_y = -1;
			end
			default: ;
		endcase
		r.filled_count = CNT_W'(filled);
		r.chunk_empty = (filled == 0);
		r.min_x = COORD_W'(pub_min_x);
		r.min_y = COORD_W'(pub_min_y);
		r.max_x = COORD_W'(pub_max_x);
		r.max_y = COORD_W'(pub_max_y);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				type_mem[i] = '0;
				colour_mem[i] = '0;
			end
			filled = 0;
			pend_min_x = GW;
			pend_min_y = GH;
			pend_max_x = -1;
			pend_max_y = -1;
			pub_min_x = GW;
			pub_min_y = GH;
			pub_max_x = -1;
			pub_max_y = -1;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				cell_result_t want;
				if (expected_results.size() == 0) begin
					report_failure("result transfer with no item outstanding");
				end else begin
					want = expected_results.pop_front();
					if (rsp.cell_type !== want.cell_type)
						report_failure($sformatf("cell_type got %0h expected %0h",
							rsp.cell_type, want.cell_type));
					if (rsp.cell_color !== want.cell_color)
						report_failure($sformatf("cell_color got %0h expected %0h",
							rsp.cell_color, want.cell_color));
					if (rsp.filled_count !== want.filled_count)
						report_failure($sformatf("filled_count got %0d expected %0d",
							rsp.filled_count, want.filled_count));
					if (rsp.chunk_empty !== want.chunk_empty)
						report_failure($sformatf("chunk_empty got %0b expected %0b",
							rsp.chunk_empty, want.chunk_empty));
					if (rsp.dirty_min_x !== want.min_x)
						report_failure($sformatf("dirty_min_x got %0h expected %0h",
							rsp.dirty_min_x, want.min_x));
					if (rsp.dirty_min_y !== want.min_y)
						report_failure($sformatf("dirty_min_y got %0h expected %0h",
							rsp.dirty_min_y, want.min_y));
					if (rsp.dirty_max_x !== want.max_x)
						report_failure($sformatf("dirty_max_x got %0h expected %0h",
							rsp.dirty_max_x, want.max_x));
					if (rsp.dirty_max_y !== want.max_y)
						report_failure($sformatf("dirty_max_y got %0h expected %0h",
							rsp.dirty_max_y, want.max_y));
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(apply_cell_op(cmd.op, cmd.cell_index,
					cmd.new_type, cmd.new_colour));
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cgdr_pkg::*;

	localparam int GW           = GRID_WIDTH_DEF;
	localparam int GH           = GRID_HEIGHT_DEF;
	localparam int CELLS        = GW * GH;
	localparam int RANDOM_ITEMS = 1830;

	logic clk = 1'b0;
	logic arst_n;
	int src_idle_pct = 25;
	int snk_idle_pct = 45;
	int hot_base;
	int fail_count;
	int pending;

	cgdr_in_if  cmd_if();
	cgdr_out_if rsp_if();

	cell_grid_dirty_rect_tracker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	cgdr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_item(op_t op, int idx, logic [NTYPE_W-1:0] ntype,
			logic [COL_W-1:0] colour);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid = 1'b1;
		cmd_if.op = op;
		cmd_if.cell_index = IDX_W'(idx);
		cmd_if.new_type = ntype;
		cmd_if.new_colour = colour;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int pick;
		int idx;
		int x;
		int y;
		op_t op;
		logic [NTYPE_W-1:0] ntype;
		pick = $urandom_range(99);
		if (pick < 45) op = OP_WRITE;
		else if (pick < 70) op = OP_READ;
		else if (pick < 85) op = OP_WAKE;
		else op = OP_FRAME;
		case ($urandom_range(3))
			0: begin
				idx = $urandom_range(CELLS - 1);
			end
			1, 2: begin
				idx = (hot_base + $urandom_range(15)) % CELLS;
			end
			default: begin
				x = $urandom_range(1) ? $urandom_range(1) : GW - 1 - $urandom_range(1);
				y = $urandom_range(GH - 1);
				idx = $urandom_range(1) ? y * GW + x : x * GW + (y % GW);
			end
		endcase
		ntype = ($urandom_range(99) < 35) ? '0 : NTYPE_W'($urandom_range(15, 1));
		send_item(op, idx, ntype, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		rsp_if.ready = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.op = OP_WRITE;
		cmd_if.cell_index = '0;
		cmd_if.new_type = '0;
		cmd_if.new_colour = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_item(OP_READ, 0, 4'h0, 32'h0000_0000);
		send_item(OP_READ, CELLS - 1, 4'hF, 32'hFFFF_FFFF);
		send_item(OP_FRAME, 0, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, 0, 4'hF, 32'hFFFF_FFFF);
		send_item(OP_WRITE, CELLS - 1, 4'h1, 32'h0000_0001);
		send_item(OP_WRITE, GW - 1, 4'h8, 32'h8000_0000);
		send_item(OP_WRITE, CELLS - GW, 4'h2, 32'h5A5A_5A5A);
		send_item(OP_FRAME, CELLS / 2 + GW / 2, 4'h0, 32'h0000_0000);
		send_item(OP_READ, 0, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, 0, 4'h4, 32'hA5A5_A5A5);
		send_item(OP_WRITE, 0, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, 0, 4'h0, 32'h1234_5678);
		send_item(OP_WAKE, CELLS / 2 + GW / 2, 4'hF, 32'hFFFF_FFFF);
		send_item(OP_FRAME, CELLS - 1, 4'h0, 32'h0000_0000);
		send_item(OP_FRAME, 0, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, CELLS - 1, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, GW - 1, 4'h0, 32'h0000_0000);
		send_item(OP_WRITE, CELLS - GW, 4'h0, 32'h0000_0000);
		send_item(OP_READ, 0, 4'h0, 32'h0000_0000);
		send_item(OP_WAKE, CELLS - 1, 4'h0, 32'h0000_0000);
		send_item(OP_WAKE, 0, 4'h0, 32'h0000_0000);
		send_item(OP_FRAME, CELLS - 1, 4'h0, 32'h0000_0000);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 25;
					snk_idle_pct = 45;
				end
				1: begin
					src_idle_pct = 45;
					snk_idle_pct = 25;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			hot_base = $urandom_range(CELLS - 1);
			repeat (RANDOM_ITEMS / 3) send_random_item();
		end
		cmd_if.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
